// File: rtl/tile_grid_collision_query_core_assert.svh
// Assertion macros for the tile grid query core.
// Each macro expects a clock named clock and a reset named reset in scope.
`ifndef TILE_GRID_COLLISION_QUERY_CORE_ASSERT_SVH
`define TILE_GRID_COLLISION_QUERY_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TGCQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tgcq assertion failed");

// Next-cycle implication, checked outside reset.
`define TGCQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tgcq assertion failed");

// Next-cycle implication, checked through reset as well.
`define TGCQ_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("tgcq assertion failed");

`endif

// File: rtl/tgcq_pkg.sv
`default_nettype none
package tgcq_pkg;

   localparam int DEF_MAX_GRID_W  = 32;
   localparam int DEF_MAX_GRID_H  = 32;
   localparam int DEF_BLOCK_SHIFT = 0;
   localparam int DEF_MAX_HITS    = 63;

   localparam int FRAC_BITS = 4;    // Q11.4 corners
   localparam int CW        = 14;   // signed grid coordinate width
   localparam int DIM_W     = 9;    // holds a grid dimension up to 256
   localparam int HIT_W     = 6;
   localparam int CFG_W     = 6;
   localparam int CSR_IDX_W = 1;
   localparam int XY_W      = 5;
   localparam int CORNER_W  = 16;

   localparam logic [CFG_W-1:0] GRID_W_RESET = 6'd15;
   localparam logic [CFG_W-1:0] GRID_H_RESET = 6'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_W = 1'b0,
      CSR_GRID_H = 1'b1
   } tgcq_csr_type;

   typedef enum logic [1:0] {
      CMD_WRITE    = 2'd0,
      CMD_OVERLAP  = 2'd1,
      CMD_SURROUND = 2'd2,
      CMD_NOP      = 2'd3
   } tgcq_cmd_type;

   typedef enum logic [1:0] {
      RSP_HIT    = 2'd0,
      RSP_DONE   = 2'd1,
      RSP_TRUNC  = 2'd2,
      RSP_REJECT = 2'd3
   } tgcq_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_OVL,
      ST_RING_COL,
      ST_RING_ROW,
      ST_FINISH
   } tgcq_state_type;

   typedef logic signed [CW-1:0] tgcq_coord_type;

   typedef struct packed {
      logic [1:0]                 command;
      logic [XY_W-1:0]            cell_x;
      logic [XY_W-1:0]            cell_y;
      logic                       occupied;
      logic signed [CORNER_W-1:0] box_min_x;
      logic signed [CORNER_W-1:0] box_min_y;
      logic signed [CORNER_W-1:0] box_max_x;
      logic signed [CORNER_W-1:0] box_max_y;
   } tgcq_req_type;

   typedef struct packed {
      logic [XY_W-1:0] hit_x;
      logic [XY_W-1:0] hit_y;
      tgcq_status_type status;
      logic            last;
   } tgcq_rsp_type;

   // One beat from the scanner to the collector, aligned with the RAM read.
   typedef struct packed {
      logic            probe;      // in-grid cell read this beat
      logic            fin;        // end of item
      logic            query_fin;  // end marker takes its status from the hit count
      tgcq_status_type status;     // end status for write commands
      logic [XY_W-1:0] x;
      logic [XY_W-1:0] y;
   } tgcq_probe_type;

   function automatic int addr_bits(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   // floor(raw / 2^shift) is an arithmetic right shift.
   function automatic tgcq_coord_type to_grid(input logic signed [CORNER_W-1:0] raw,
                                              input int shift);
      logic signed [CORNER_W-1:0] t;
      t = raw >>> shift;
      return tgcq_coord_type'(t[CW-1:0]);
   endfunction

endpackage
`default_nettype wire

// File: rtl/tgcq_ram.sv
`default_nettype none
module tgcq_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we_i,
   input  wire logic [AW-1:0]    addr_i,
   input  wire logic [WIDTH-1:0] wdata_i,
   output logic      [WIDTH-1:0] rdata_o
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we_i) begin
         mem_ff[addr_i] <= wdata_i;
      end
      rdata_ff <= mem_ff[addr_i];
   end

   assign rdata_o = rdata_ff;

endmodule
`default_nettype wire

// File: rtl/tgcq_scan.sv
`default_nettype none
module tgcq_scan
   import tgcq_pkg::*;
#(
   parameter int MAX_GRID_W  = DEF_MAX_GRID_W,
   parameter int MAX_GRID_H  = DEF_MAX_GRID_H,
   parameter int BLOCK_SHIFT = DEF_BLOCK_SHIFT,
   localparam int XW = addr_bits(MAX_GRID_W),
   localparam int YW = addr_bits(MAX_GRID_H),
   localparam int AW = XW + YW
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [DIM_W-1:0] ew_i,
   input  wire logic [DIM_W-1:0] eh_i,
   input  wire logic             start_i,
   input  wire tgcq_req_type     req_i,
   output logic                  busy_o,
   output logic                  mem_we_o,
   output logic [AW-1:0]         mem_addr_o,
   output logic                  mem_wdata_o,
   output tgcq_probe_type        probe_o
);

   localparam int SHIFT = FRAC_BITS + BLOCK_SHIFT;
   localparam tgcq_coord_type ZERO = '0;
   localparam tgcq_coord_type ONE  = tgcq_coord_type'(1);
   localparam tgcq_coord_type TWO  = tgcq_coord_type'(2);

   tgcq_state_type state_ff, state_in;
   tgcq_cmd_type   cmd_ff, cmd_in;
   logic [XY_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic            occ_ff, occ_in;
   logic            ovl_go_ff, ovl_go_in;
   logic            sub_ff, sub_in;
   tgcq_coord_type  lo_x_ff, lo_x_in, hi_x_ff, hi_x_in;
   tgcq_coord_type  lo_y_ff, lo_y_in, hi_y_ff, hi_y_in;
   tgcq_coord_type  px_ff, px_in, py_ff, py_in;
   logic [AW-1:0]   clr_ff, clr_in;

   tgcq_coord_type ewc, ehc;
   tgcq_coord_type gx0, gy0, gx1, gy1, mnx, mny, mxx, mxy;
   logic [CW-1:0]  wx, wy;
   logic           in_grid, wr_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      cmd_ff    <= cmd_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      occ_ff    <= occ_in;
      ovl_go_ff <= ovl_go_in;
      sub_ff    <= sub_in;
      lo_x_ff   <= lo_x_in;
      hi_x_ff   <= hi_x_in;
      lo_y_ff   <= lo_y_in;
      hi_y_ff   <= hi_y_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
   end

   always_comb begin
      ewc = $signed({{(CW-DIM_W){1'b0}}, ew_i});
      ehc = $signed({{(CW-DIM_W){1'b0}}, eh_i});

      gx0 = to_grid(req_i.box_min_x, SHIFT);
      gy0 = to_grid(req_i.box_min_y, SHIFT);
      gx1 = to_grid(req_i.box_max_x, SHIFT);
      gy1 = to_grid(req_i.box_max_y, SHIFT);
      mnx = (gx0 < ZERO) ? ZERO : gx0;
      mny = (gy0 < ZERO) ? ZERO : gy0;
      mxx = (gx1 > ewc) ? ewc : gx1;
      mxy = (gy1 > ehc) ? ehc : gy1;

      in_grid = !px_ff[CW-1] && (px_ff < ewc) && !py_ff[CW-1] && (py_ff < ehc);
      wr_ok   = ({{(DIM_W-XY_W){1'b0}}, cx_ff} < ew_i) &&
                ({{(DIM_W-XY_W){1'b0}}, cy_ff} < eh_i);
      wx      = {{(CW-XY_W){1'b0}}, cx_ff};
      wy      = {{(CW-XY_W){1'b0}}, cy_ff};

      state_in  = state_ff;
      cmd_in    = cmd_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      occ_in    = occ_ff;
      ovl_go_in = ovl_go_ff;
      sub_in    = sub_ff;
      lo_x_in   = lo_x_ff;
      hi_x_in   = hi_x_ff;
      lo_y_in   = lo_y_ff;
      hi_y_in   = hi_y_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      clr_in    = clr_ff;

      mem_we_o    = 1'b0;
      mem_addr_o  = {px_ff[XW-1:0], py_ff[YW-1:0]};
      mem_wdata_o = occ_ff;

      probe_o           = '0;
      probe_o.status    = RSP_DONE;
      probe_o.x         = px_ff[XY_W-1:0];
      probe_o.y         = py_ff[XY_W-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we_o    = 1'b1;
            mem_addr_o  = clr_ff;
            mem_wdata_o = 1'b0;
            clr_in      = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start_i) begin
               cmd_in    = tgcq_cmd_type'(req_i.command);
               cx_in     = req_i.cell_x;
               cy_in     = req_i.cell_y;
               occ_in    = req_i.occupied;
               ovl_go_in = !req_i.box_min_x[CORNER_W-1] && !req_i.box_min_y[CORNER_W-1] &&
                           (gx1 < ewc) && (gy1 < ehc) && (gx0 <= gx1) && (gy0 <= gy1);
               if (tgcq_cmd_type'(req_i.command) == CMD_OVERLAP) begin
                  lo_x_in = gx0;
                  hi_x_in = gx1;
                  lo_y_in = gy0;
                  hi_y_in = gy1;
               end else begin
                  // ring bounds: one cell outside the clamped box
                  lo_x_in = mnx - ONE;
                  hi_x_in = mxx + ONE;
                  lo_y_in = mny - ONE;
                  hi_y_in = mxy + ONE;
               end
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            unique case (cmd_ff)
               CMD_WRITE: begin
                  mem_we_o          = wr_ok;
                  mem_addr_o        = {wx[XW-1:0], wy[YW-1:0]};
                  probe_o.fin       = 1'b1;
                  probe_o.status    = wr_ok ? RSP_DONE : RSP_REJECT;
                  probe_o.x         = '0;
                  probe_o.y         = '0;
                  state_in          = ST_IDLE;
               end
               CMD_OVERLAP: begin
                  px_in    = lo_x_ff;
                  py_in    = lo_y_ff;
                  state_in = ovl_go_ff ? ST_OVL : ST_FINISH;
               end
               CMD_SURROUND: begin
                  sub_in = 1'b0;
                  priority if (lo_x_ff <= hi_x_ff) begin
                     px_in    = lo_x_ff;
                     py_in    = lo_y_ff;
                     state_in = ST_RING_COL;
                  end else if ((lo_y_ff + TWO) <= hi_y_ff) begin
                     px_in    = lo_x_ff;
                     py_in    = lo_y_ff + ONE;
                     state_in = ST_RING_ROW;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_OVL: begin
            probe_o.probe = in_grid;
            if (py_ff == hi_y_ff) begin
               py_in = lo_y_ff;
               if (px_ff == hi_x_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  px_in = px_ff + ONE;
               end
            end else begin
               py_in = py_ff + ONE;
            end
         end
         ST_RING_COL: begin
            probe_o.probe = in_grid;
            if (!sub_ff) begin
               py_in  = hi_y_ff;
               sub_in = 1'b1;
            end else begin
               sub_in = 1'b0;
               if (px_ff == hi_x_ff) begin
                  px_in = lo_x_ff;
                  py_in = lo_y_ff + ONE;
                  state_in = ((lo_y_ff + TWO) <= hi_y_ff) ? ST_RING_ROW : ST_FINISH;
               end else begin
                  px_in = px_ff + ONE;
                  py_in = lo_y_ff;
               end
            end
         end
         ST_RING_ROW: begin
            probe_o.probe = in_grid;
            if (!sub_ff) begin
               px_in  = hi_x_ff;
               sub_in = 1'b1;
            end else begin
               sub_in = 1'b0;
               px_in  = lo_x_ff;
               if (py_ff == (hi_y_ff - ONE)) begin
                  state_in = ST_FINISH;
               end else begin
                  py_in = py_ff + ONE;
               end
            end
         end
         ST_FINISH: begin
            probe_o.fin       = 1'b1;
            probe_o.query_fin = 1'b1;
            probe_o.x         = '0;
            probe_o.y         = '0;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      busy_o = (state_ff != ST_IDLE);
   end

endmodule
`default_nettype wire

// File: rtl/tgcq_collect.sv
`default_nettype none
module tgcq_collect
   import tgcq_pkg::*;
#(
   parameter int MAX_HITS = DEF_MAX_HITS
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire tgcq_probe_type probe_i,
   input  wire logic           rd_data_i,
   output logic                rsp_valid_o,
   output tgcq_rsp_type        rsp_o
);

   localparam logic [HIT_W-1:0] HIT_LIMIT = HIT_W'(MAX_HITS);

   tgcq_probe_type   stg_ff, stg_in;
   logic [HIT_W-1:0] hits_ff, hits_in;
   logic             trunc_ff, trunc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   tgcq_rsp_type     rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_ff       <= '0;
         hits_ff      <= '0;
         trunc_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stg_ff       <= stg_in;
         hits_ff      <= hits_in;
         trunc_ff     <= trunc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // The staged beat lines up with the RAM data read for it.
   always_comb begin
      stg_in       = probe_i;
      hits_in      = hits_ff;
      trunc_in     = trunc_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      priority if (stg_ff.probe && rd_data_i) begin
         if (hits_ff == HIT_LIMIT) begin
            trunc_in = 1'b1;   // drop the hit, flag the end marker
         end else begin
            hits_in      = hits_ff + 1'b1;
            rsp_valid_in = 1'b1;
            rsp_in.hit_x  = stg_ff.x;
            rsp_in.hit_y  = stg_ff.y;
            rsp_in.status = RSP_HIT;
            rsp_in.last   = 1'b0;
         end
      end else if (stg_ff.fin) begin
         rsp_valid_in  = 1'b1;
         rsp_in.hit_x  = '0;
         rsp_in.hit_y  = '0;
         rsp_in.last   = 1'b1;
         if (stg_ff.query_fin) begin
            rsp_in.status = trunc_ff ? RSP_TRUNC : RSP_DONE;
         end else begin
            rsp_in.status = stg_ff.status;
         end
         hits_in  = '0;
         trunc_in = 1'b0;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid_o = rsp_valid_ff;
   assign rsp_o       = rsp_ff;

endmodule
`default_nettype wire

// File: rtl/tile_grid_collision_query_core.sv
// Tile grid occupancy map with write, overlap and surround commands. A command
// is taken when start is high and busy is low; every command ends with one
// result with last set, and the receiver must take each result in the cycle
// rsp_valid is high, as there is no back-pressure. After reset the map is
// cleared one cell per cycle, every cell of the map, with busy high; grid size
// registers can be written at any time via csr_* but should change only while
// busy is low. Cost per command is set by the single read port of the occupancy
// RAM, one cell per cycle: an overlap query reads each cell of the box and a
// surround query each cell of the ring around it; each result is registered in
// the collector behind the RAM read.
`default_nettype none
module tile_grid_collision_query_core
   import tgcq_pkg::*;
#(
   parameter int MAX_GRID_W  = DEF_MAX_GRID_W,
   parameter int MAX_GRID_H  = DEF_MAX_GRID_H,
   parameter int BLOCK_SHIFT = DEF_BLOCK_SHIFT,
   parameter int MAX_HITS    = DEF_MAX_HITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire tgcq_req_type         req_item,
   output logic                      rsp_valid,
   output tgcq_rsp_type              rsp_item,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   localparam int AW = addr_bits(MAX_GRID_W) + addr_bits(MAX_GRID_H);
   localparam logic [DIM_W-1:0] MAX_W = DIM_W'(MAX_GRID_W);
   localparam logic [DIM_W-1:0] MAX_H = DIM_W'(MAX_GRID_H);

   logic [CFG_W-1:0] grid_w_ff, grid_w_in, grid_h_ff, grid_h_in;
   logic [DIM_W-1:0] ew, eh;
   logic             mem_we, mem_wdata, mem_rdata;
   logic [AW-1:0]    mem_addr;
   tgcq_probe_type   probe;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_w_ff <= GRID_W_RESET;
         grid_h_ff <= GRID_H_RESET;
      end else begin
         grid_w_ff <= grid_w_in;
         grid_h_ff <= grid_h_in;
      end
   end

   always_comb begin
      grid_w_in = grid_w_ff;
      grid_h_in = grid_h_ff;
      if (csr_valid && csr_ready) begin
         unique case (tgcq_csr_type'(csr_index))
            CSR_GRID_W: grid_w_in = csr_wdata;
            CSR_GRID_H: grid_h_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Saturate the in-use size at the map size.
   always_comb begin
      ew = ({{(DIM_W-CFG_W){1'b0}}, grid_w_ff} > MAX_W) ? MAX_W
                                                       : {{(DIM_W-CFG_W){1'b0}}, grid_w_ff};
      eh = ({{(DIM_W-CFG_W){1'b0}}, grid_h_ff} > MAX_H) ? MAX_H
                                                       : {{(DIM_W-CFG_W){1'b0}}, grid_h_ff};
   end

   assign csr_ready = 1'b1;

   tgcq_scan #(
      .MAX_GRID_W  (MAX_GRID_W),
      .MAX_GRID_H  (MAX_GRID_H),
      .BLOCK_SHIFT (BLOCK_SHIFT)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .ew_i        (ew),
      .eh_i        (eh),
      .start_i     (start),
      .req_i       (req_item),
      .busy_o      (busy),
      .mem_we_o    (mem_we),
      .mem_addr_o  (mem_addr),
      .mem_wdata_o (mem_wdata),
      .probe_o     (probe)
   );

   tgcq_ram #(
      .WIDTH (1),
      .DEPTH (1 << AW)
   ) u_map (
      .clock   (clock),
      .we_i    (mem_we),
      .addr_i  (mem_addr),
      .wdata_i (mem_wdata),
      .rdata_o (mem_rdata)
   );

   tgcq_collect #(
      .MAX_HITS (MAX_HITS)
   ) u_collect (
      .clock       (clock),
      .reset       (reset),
      .probe_i     (probe),
      .rd_data_i   (mem_rdata),
      .rsp_valid_o (rsp_valid),
      .rsp_o       (rsp_item)
   );

endmodule
`default_nettype wire

// File: rtl/tgcq_checker.sv
`default_nettype none
`include "tile_grid_collision_query_core_assert.svh"
module tgcq_checker
   import tgcq_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         start,
   input wire logic         busy,
   input wire logic         rsp_valid,
   input wire tgcq_rsp_type rsp_item
);

   // last marks exactly the end-of-item beats, which never carry a hit status
   `TGCQ_ASSERT_NOW(a_last_vs_status, rsp_valid, rsp_item.last == (rsp_item.status != RSP_HIT))
   // end markers carry no coordinates
   `TGCQ_ASSERT_NOW(a_end_zero_xy, rsp_valid && rsp_item.last, {rsp_item.hit_x, rsp_item.hit_y} == '0)
   // the next item cannot produce a beat right after an end beat
   `TGCQ_ASSERT_NEXT(a_gap_after_last, rsp_valid && rsp_item.last, !rsp_valid)
   // an accepted command makes the block busy in the next cycle
   `TGCQ_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)
   // right after reset no result comes out of the block and the block is busy
   `TGCQ_ASSERT_NEXT_ALWAYS(a_quiet_after_reset, reset, !rsp_valid && busy)

endmodule

bind tile_grid_collision_query_core tgcq_checker u_tgcq_checker (.*);
`default_nettype wire
